/* src/utf8_to_codepoint_decoder_assert.svh */
// Assertion macros shared by the decoder modules.
// Each expects clk and rst_n in scope; checks are off while reset is low.
`ifndef UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define UTF8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define UTF8D_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/utf8d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  localparam int CODE_W = 21;

  // Replacement code point for any decode error
  localparam logic [CODE_W-1:0] REPL_CODE = 21'h00FFFD;

  // Number of results caused by one input byte
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_ONE  = 2'd1,
    RES_TWO  = 2'd2
  } res_cnt_t;

  // Decoder state carried from one byte to the next
  typedef struct packed {
    logic [CODE_W-1:0] partial;
    logic [1:0]        pend;
    logic              skip;
  } dec_state_t;

  // Results of one byte: code0 is first, code1 is used only for two results
  typedef struct packed {
    res_cnt_t          cnt;
    logic [CODE_W-1:0] code0;
    logic [CODE_W-1:0] code1;
  } dec_res_t;

endpackage

`default_nettype wire

/* src/utf8d_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step (
  input  wire logic [7:0]           byte_i,
  input  wire utf8d_pkg::dec_state_t st_i,
  output utf8d_pkg::dec_state_t     st_o,
  output utf8d_pkg::dec_res_t       res_o
);
  import utf8d_pkg::*;

  logic              is_cont;
  logic [CODE_W-1:0] acc;
  logic [1:0]        pend_dec;
  // lead byte decode
  logic              ld_emit;
  logic [CODE_W-1:0] ld_code;
  logic [CODE_W-1:0] ld_partial;
  logic [1:0]        ld_pend;
  logic              ld_skip;

  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign acc      = {st_i.partial[CODE_W-7:0], byte_i[5:0]};
  assign pend_dec = st_i.pend - 2'd1;

  // Decode the byte as a fresh lead byte
  always_comb begin
    ld_emit    = 1'b0;
    ld_code    = REPL_CODE;
    ld_partial = '0;
    ld_pend    = 2'd0;
    ld_skip    = 1'b0;
    priority if (byte_i[7] == 1'b0) begin
      ld_emit = 1'b1;
      ld_code = {{(CODE_W-8){1'b0}}, byte_i};
    end else if (byte_i[7:5] == 3'b110) begin
      ld_partial = {{(CODE_W-5){1'b0}}, byte_i[4:0]};
      ld_pend    = 2'd1;
    end else if (byte_i[7:4] == 4'b1110) begin
      ld_partial = {{(CODE_W-4){1'b0}}, byte_i[3:0]};
      ld_pend    = 2'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      ld_partial = {{(CODE_W-3){1'b0}}, byte_i[2:0]};
      ld_pend    = 2'd3;
    end else begin
      // stray continuation or bad lead: replace and drop what follows
      ld_emit = 1'b1;
      ld_skip = 1'b1;
    end
  end

  // Combine pending sequence, skip mode and end of text
  always_comb begin
    st_o      = st_i;
    res_o.cnt = RES_NONE;
    res_o.code0 = REPL_CODE;
    res_o.code1 = ld_code;
    priority if (byte_i == 8'h00) begin
      // end of text
      res_o.cnt = (st_i.pend != 2'd0) ? RES_ONE : RES_NONE;
      st_o      = '0;
    end else if (st_i.pend != 2'd0 && is_cont) begin
      st_o.pend = pend_dec;
      if (pend_dec == 2'd0) begin
        res_o.cnt   = RES_ONE;
        res_o.code0 = acc;
        st_o.partial = '0;
      end else begin
        st_o.partial = acc;
      end
    end else if (st_i.pend != 2'd0) begin
      // missing continuation: replace, then decode afresh
      st_o.partial = ld_partial;
      st_o.pend    = ld_pend;
      st_o.skip    = st_i.skip | ld_skip;
      res_o.cnt    = ld_emit ? RES_TWO : RES_ONE;
    end else if (st_i.skip && is_cont) begin
      // drop continuation in skip mode
      st_o = st_i;
    end else begin
      st_o.partial = ld_partial;
      st_o.pend    = ld_pend;
      st_o.skip    = ld_skip;
      res_o.cnt    = ld_emit ? RES_ONE : RES_NONE;
      res_o.code0  = ld_code;
    end
  end

endmodule

`default_nettype wire

/* src/utf8d_outq.sv */
`timescale 1ns / 1ps
`default_nettype none

module utf8d_outq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push_i,
  input  wire utf8d_pkg::dec_res_t     res_i,
  output logic                         room2_o,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [utf8d_pkg::CODE_W-1:0] out_code_point,
  output logic                         out_last_of_run
);
  import utf8d_pkg::*;

  logic [CODE_W-1:0] code_mem_r [4];
  logic              last_mem_r [4];
  logic [1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [2:0]        count_r, count_nxt;
  logic [1:0]        push_n;
  logic              pop;
  logic [1:0]        wr_ptr_p1;

  assign push_n    = push_i ? res_i.cnt : 2'd0;
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;
  assign room2_o   = (count_r <= 3'd2);

  assign out_valid       = (count_r != 3'd0);
  assign out_code_point  = code_mem_r[rd_ptr_r];
  assign out_last_of_run = last_mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write one or two result beats
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      code_mem_r[wr_ptr_r] <= res_i.code0;
      last_mem_r[wr_ptr_r] <= (push_n == 2'd1);
    end
    if (push_n == 2'd2) begin
      code_mem_r[wr_ptr_p1] <= res_i.code1;
      last_mem_r[wr_ptr_p1] <= 1'b1;
    end
  end

`include "utf8_to_codepoint_decoder_assert.svh"

  `UTF8D_NEVER(a_no_overflow, count_r > 3'd4, "output queue overflow")
  `UTF8D_NEVER(a_push_needs_room, push_n != 2'd0 && !room2_o, "push without room")
  `UTF8D_ASSERT(a_idle_hold, (push_n == 2'd0 && !pop) |=> $stable(count_r), "count moved")

endmodule

`default_nettype wire

/* src/utf8_to_codepoint_decoder.sv */
// Each accepted byte is registered, decoded combinationally and queued as result beats.
// Throughput: one byte per cycle unless in_stall; each byte gives zero, one or two beats.
// A 4-entry result queue sets the pace: a new byte moves on only while two entries are free.
// Reset (rst_n low, synchronous) clears the decode state, the input stage and the queue.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_codepoint_decoder (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              in_byte,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [utf8d_pkg::CODE_W-1:0] out_code_point,
  output logic                         out_last_of_run
);
  import utf8d_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  dec_state_t st_r, st_nxt;
  dec_res_t   res;
  logic       room2;
  logic       advance;
  logic       in_take;

  assign advance  = vld_r && room2;
  assign in_stall = vld_r && !room2;
  assign in_take  = in_valid && !in_stall;
  assign vld_nxt  = in_take || (vld_r && !advance);

  // Hold the input beat until the queue has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte;
    end
  end

  utf8d_step u_step (
    .byte_i (byte_r),
    .st_i   (st_r),
    .st_o   (st_nxt),
    .res_o  (res)
  );

  // Update decode state as each byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  utf8d_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push_i          (advance),
    .res_i           (res),
    .room2_o         (room2),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_last_of_run (out_last_of_run)
  );

`include "utf8_to_codepoint_decoder_assert.svh"

  `UTF8D_NEVER(a_skip_no_pend, st_r.skip && st_r.pend != 2'd0, "skip with pending sequence")
  `UTF8D_ASSERT(a_idle_partial, (st_r.pend == 2'd0) |-> (st_r.partial == '0), "stale partial")
  `UTF8D_ASSERT(a_state_hold, !advance |=> $stable(st_r), "state moved without byte")

endmodule

`default_nettype wire

/* bench/utf8_to_codepoint_decoder_test.sv */
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder_test;
  import utf8d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 32;

  // One expected result beat
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } cp_beat_t;

  // Tracks decoder state and the code point beats still owed by the block
  class utf8_decode_tracker;
    logic [CODE_W-1:0] partial;
    logic [1:0]        pend;
    bit                skip;
    cp_beat_t          due_beats[$];
    logic [CODE_W-1:0] run_codes[$];
    int                errors;

    function new();
      partial = '0;
      pend    = '0;
      skip    = 1'b0;
      errors  = 0;
    endfunction

    // Decode a nonzero byte as the start of a new sequence
    function void decode_lead(logic [7:0] b);
      if (b < 8'h80) begin
        run_codes.push_back(CODE_W'(b));
      end else if ((b & 8'hE0) == 8'hC0) begin
        partial = CODE_W'(b & 8'h1F);
        pend    = 2'd1;
      end else if ((b & 8'hF0) == 8'hE0) begin
        partial = CODE_W'(b & 8'h0F);
        pend    = 2'd2;
      end else if ((b & 8'hF8) == 8'hF0) begin
        partial = CODE_W'(b & 8'h07);
        pend    = 2'd3;
      end else begin
        // stray continuation or bad lead: replace and drop what follows
        partial = '0;
        pend    = '0;
        skip    = 1'b1;
        run_codes.push_back(REPL_CODE);
      end
    endfunction

    // Advance the state by one accepted byte and queue its code points
    function void note_byte(logic [7:0] b);
      bit       is_cont;
      cp_beat_t beat;
      is_cont = (b[7:6] == 2'b10);
      run_codes.delete();
      if (b == 8'h00) begin
        // end of text: flag an open sequence, then clear everything
        if (pend != 0) run_codes.push_back(REPL_CODE);
        partial = '0;
        pend    = '0;
        skip    = 1'b0;
      end else if (pend != 0) begin
        if (is_cont) begin
          partial = {partial[CODE_W-7:0], b[5:0]};
          pend    = pend - 2'd1;
          if (pend == 0) begin
            run_codes.push_back(partial);
            partial = '0;
          end
        end else begin
          // missing continuation: replace, then decode this byte afresh
          run_codes.push_back(REPL_CODE);
          partial = '0;
          pend    = '0;
          decode_lead(b);
        end
      end else if (!(skip && is_cont)) begin
        skip = 1'b0;
        decode_lead(b);
      end
      foreach (run_codes[i]) begin
        beat.code = run_codes[i];
        beat.last = (i == run_codes.size() - 1);
        due_beats.push_back(beat);
      end
    endfunction

    // Compare one accepted result beat with the oldest one owed
    function void check_beat(logic [CODE_W-1:0] code, logic last);
      cp_beat_t want;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual code %h last %b",
                 $time, code, last);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      if (want.code !== code) begin
        $display("%0t: code point mismatch, expected %h, actual %h", $time, want.code, code);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last_of_run mismatch, expected %b, actual %b", $time, want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due_beats.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_byte;
  logic              out_valid;
  logic              out_stall;
  logic [CODE_W-1:0] out_code_point;
  logic              out_last_of_run;

  utf8_decode_tracker tracker;
  bit                 gaps_on;
  bit                 hold_req;
  int                 hold_left;
  int                 bytes_sent;
  int                 cycle_count;

  utf8_to_codepoint_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_last_of_run (out_last_of_run)
  );

  always #1 clk = ~clk;

  // Offer one byte, idling at random first, and hold it until accepted
  task send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  function logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Send one random unit: mostly well-formed sequences, some noise
  task send_random_unit();
    int kind;
    int n;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (kind < 38) begin
      send_byte(8'hC0 | 8'($urandom_range(0, 31)));
      send_byte(cont_byte());
    end else if (kind < 56) begin
      send_byte(8'hE0 | 8'($urandom_range(0, 15)));
      repeat (2) send_byte(cont_byte());
    end else if (kind < 74) begin
      send_byte(8'hF0 | 8'($urandom_range(0, 7)));
      repeat (3) send_byte(cont_byte());
    end else if (kind < 84) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 91) begin
      // cut a sequence short; the next unit usually breaks it
      n = $urandom_range(1, 3);
      case (n)
        1: begin
          send_byte(8'hC0 | 8'($urandom_range(0, 31)));
        end
        2: begin
          send_byte(8'hE0 | 8'($urandom_range(0, 15)));
        end
        default: begin
          send_byte(8'hF0 | 8'($urandom_range(0, 7)));
        end
      endcase
      k = $urandom_range(0, n - 1);
      repeat (k) send_byte(cont_byte());
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 3)) send_byte(cont_byte());
    end else if (kind < 98) begin
      send_byte(8'h00);
    end else begin
      send_byte(8'hF8 | 8'($urandom_range(0, 7)));
      repeat ($urandom_range(0, 3)) send_byte(cont_byte());
    end
  endtask

  // Drop valid and wait for every owed beat to arrive
  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Result side: check accepted beats, then pick the next stall value
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        tracker.check_beat(out_code_point, out_last_of_run);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (gaps_on) begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if it never drains
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    logic [7:0] directed[] = '{
      8'h41, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC0, 8'h80,
      8'h80, 8'hBF, 8'h41, 8'hE2, 8'h41, 8'hF0, 8'hC3, 8'hA9, 8'hE2, 8'h00,
      8'hFF, 8'h80, 8'h00, 8'hE0, 8'hFF, 8'h7F
    };
    in_valid   <= 1'b0;
    in_byte    <= 8'h00;
    rst_n      <= 1'b0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    bytes_sent = 0;
    tracker    = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes and every special case
    foreach (directed[i]) send_byte(directed[i]);

    while (bytes_sent < 450) send_random_unit();

    // Hold the result side off while bytes keep coming
    hold_req = 1'b1;
    repeat (40) send_random_unit();

    // Pause the input until the block has drained
    wait_drained();

    // Stretch with no idling on either side
    gaps_on = 1'b0;
    while (bytes_sent < 750) send_random_unit();
    gaps_on = 1'b1;
    while (bytes_sent < 1230) send_random_unit();

    wait_drained();
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0)
      $display("%0t: %0d expected beats never arrived", $time, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
